@@ rtl/core/sorted_array_table_core_assert.svh @@
// Assertion macros shared by the sorted array table checker.
`ifndef SORTED_ARRAY_TABLE_CORE_ASSERT_SVH
`define SORTED_ARRAY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sorted array table: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sorted array table: assertion failed");

`endif

@@ rtl/core/sat_pkg.sv @@
// Shared constants, codes and controller/datapath types of the sorted array table.
package sat_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned OP_W   = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ECNT_W = 7;
  localparam int unsigned PL_W   = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_WALK,
    S_INS_PLACE,
    S_REM_WALK,
    S_LOOK_WAIT
  } state_e;

  typedef enum logic [2:0] {
    RA_CNT_M1,
    RA_POS,
    RA_POS_P1,
    RA_K_M1,
    RA_K_P2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_ZERO,
    WA_K,
    WA_K_P1
  } wa_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [2:0] {
    K_HOLD,
    K_CNT_M1,
    K_POS,
    K_DEC,
    K_INC
  } k_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    logic    wr_en;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    k_op_e   k_op;
    cnt_op_e cnt_op;
    logic    emit;
    status_e status;
    logic    rv_sel;
    logic    pl_sel;
  } sat_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            oob;
    logic            empty;
    logic            rem_last;
    logic            ge;
    logic            k_zero;
    logic            walk_end;
  } sat_stat_t;

endpackage

@@ rtl/core/sat_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sat_ctrl.sv @@
// Sequencing state machine of the sorted array table.
module sat_ctrl import sat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sat_stat_t stat_i,
  output sat_cmd_t  cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_INSERT: begin
            state_d = (stat_i.full || stat_i.empty) ? S_IDLE : S_INS_WALK;
          end
          OP_LOOKUP: begin
            state_d = stat_i.oob ? S_IDLE : S_LOOK_WAIT;
          end
          OP_REMOVE: begin
            state_d = (stat_i.oob || stat_i.rem_last) ? S_IDLE : S_REM_WALK;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_INS_WALK: begin
        if (!stat_i.ge) begin
          state_d = S_IDLE;
        end else if (stat_i.k_zero) begin
          state_d = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        state_d = S_IDLE;
      end
      S_REM_WALK: begin
        if (stat_i.walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_LOOK_WAIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = RA_K_M1;
    cmd_o.wa_sel  = WA_ZERO;
    cmd_o.wd_sel  = WD_VALUE;
    cmd_o.k_op    = K_HOLD;
    cmd_o.cnt_op  = CNT_HOLD;
    cmd_o.status  = ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = start_i;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_FULL;
            end else if (stat_i.empty) begin
              // First entry goes straight to slot zero.
              cmd_o.wr_en  = 1'b1;
              cmd_o.cnt_op = CNT_INC;
              cmd_o.emit   = 1'b1;
            end else begin
              cmd_o.rd_sel = RA_CNT_M1;
              cmd_o.k_op   = K_CNT_M1;
            end
          end
          OP_LOOKUP: begin
            if (stat_i.oob) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_RANGE;
            end else begin
              cmd_o.rd_sel = RA_POS;
            end
          end
          OP_REMOVE: begin
            if (stat_i.oob) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_RANGE;
            end else if (stat_i.rem_last) begin
              // Removing the top entry needs no shifting.
              cmd_o.cnt_op = CNT_DEC;
              cmd_o.emit   = 1'b1;
            end else begin
              cmd_o.rd_sel = RA_POS_P1;
              cmd_o.k_op   = K_POS;
            end
          end
          default: begin
            cmd_o.emit = 1'b1;
          end
        endcase
      end
      S_INS_WALK: begin
        cmd_o.rd_sel = RA_K_M1;
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_K_P1;
        if (stat_i.ge) begin
          cmd_o.wd_sel = WD_RDATA;
          cmd_o.k_op   = K_DEC;
        end else begin
          cmd_o.wd_sel = WD_VALUE;
          cmd_o.cnt_op = CNT_INC;
          cmd_o.emit   = 1'b1;
          cmd_o.pl_sel = 1'b1;
        end
      end
      S_INS_PLACE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.cnt_op = CNT_INC;
        cmd_o.emit   = 1'b1;
      end
      S_REM_WALK: begin
        cmd_o.rd_sel = RA_K_P2;
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_K;
        cmd_o.wd_sel = WD_RDATA;
        if (stat_i.walk_end) begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.emit   = 1'b1;
        end else begin
          cmd_o.k_op = K_INC;
        end
      end
      S_LOOK_WAIT: begin
        cmd_o.emit   = 1'b1;
        cmd_o.rv_sel = 1'b1;
      end
      default: begin
        cmd_o.capture = 1'b0;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ rtl/core/sat_dp.sv @@
// Datapath of the sorted array table: entry memory, count, walk index and result registers.
module sat_dp import sat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sat_cmd_t          cmd_i,
  output sat_stat_t         stat_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  output logic              done_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [STAT_W-1:0] status_o,
  output logic [ECNT_W-1:0] entry_count_o,
  output logic [PL_W-1:0]   placed_at_o
);

  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cap_eff;
  logic [ADDR_W-1:0]     k_q, k_d;
  logic [WORD_WIDTH-1:0] val_q;
  logic [POS_W-1:0]      pos_q;
  logic [OP_W-1:0]       op_q;

  logic                  done_q;
  logic [WORD_WIDTH-1:0] rv_q;
  logic [STAT_W-1:0]     st_q;
  logic [CNT_W-1:0]      ec_q;
  logic [ADDR_W-1:0]     pl_q;

  logic [ADDR_W-1:0]     raddr, waddr;
  logic [WORD_WIDTH-1:0] wdata, rdata;

  sat_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Effective capacity is the configured value limited to the table depth.
  assign cap_eff = (32'(cap_q) >= 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RA_CNT_M1: raddr = ADDR_W'(cnt_q - CNT_W'(1));
      RA_POS:    raddr = ADDR_W'(pos_q);
      RA_POS_P1: raddr = ADDR_W'(pos_q) + ADDR_W'(1);
      RA_K_M1:   raddr = k_q - ADDR_W'(1);
      RA_K_P2:   raddr = k_q + ADDR_W'(2);
      default:   raddr = k_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wa_sel)
      WA_ZERO: waddr = '0;
      WA_K:    waddr = k_q;
      WA_K_P1: waddr = k_q + ADDR_W'(1);
      default: waddr = '0;
    endcase
  end

  assign wdata = (cmd_i.wd_sel == WD_RDATA) ? rdata : val_q;

  always_comb begin
    case (cmd_i.k_op)
      K_CNT_M1: k_d = ADDR_W'(cnt_q - CNT_W'(1));
      K_POS:    k_d = ADDR_W'(pos_q);
      K_DEC:    k_d = k_q - ADDR_W'(1);
      K_INC:    k_d = k_q + ADDR_W'(1);
      default:  k_d = k_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CNT_W'(1);
      CNT_DEC: cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      cnt_q  <= cnt_d;
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.capture) begin
      val_q <= WORD_WIDTH'(new_value_i);
      pos_q <= position_i;
      op_q  <= op_i;
    end
    if (cmd_i.emit) begin
      rv_q <= cmd_i.rv_sel ? rdata : '0;
      st_q <= cmd_i.status;
      ec_q <= cnt_d;
      pl_q <= cmd_i.pl_sel ? (k_q + ADDR_W'(1)) : '0;
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (cnt_q >= cap_eff);
  assign stat_o.oob      = (32'(pos_q) >= 32'(cnt_q));
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.rem_last = ((32'(pos_q) + 32'd1) == 32'(cnt_q));
  assign stat_o.ge       = (rdata >= val_q);
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.walk_end = ((CNT_W'(k_q) + CNT_W'(2)) == cnt_q);

  assign done_o        = done_q;
  assign read_value_o  = VAL_W'(rv_q);
  assign status_o      = st_q;
  assign entry_count_o = ECNT_W'(ec_q);
  assign placed_at_o   = PL_W'(pl_q);

endmodule

@@ rtl/core/sorted_array_table_core.sv @@
// Top level of the sorted array table: controller plus datapath.
//
//   Channel   Handshake                 Payload
//   request   start_i / busy_o          op_i, new_value_i, position_i
//   result    done_o (one-cycle strobe) read_value_o, status_o, entry_count_o, placed_at_o
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// A request is taken when start_i is high while busy_o is low. Its result is
// strobed on done_o for one cycle, in the cycle after the last step of the work.
// Rejected requests, unused codes, an insert into an empty table and removal of the
// top entry finish in the decode state, and a lookup adds a wait state for the read.
// Insert walks down from the top entry, one entry per cycle through the single read
// port of the entry memory; remove walks up from the removed index. The longest
// request is an insert at slot zero into 63 entries. A new request can be taken in
// the cycle in which the result is strobed.
// Reset clears the count and sets the capacity to 64; the entry memory needs
// no clearing because only entries below the count are ever used.
// The receiver cannot stall results, so nothing is held back on the output side.
module sorted_array_table_core import sat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              done_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [STAT_W-1:0] status_o,
  output logic [ECNT_W-1:0] entry_count_o,
  output logic [PL_W-1:0]   placed_at_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i
);

  sat_cmd_t  cmd;
  sat_stat_t stat;
  logic      busy;

  // The controller sees the request strobe only while idle, which makes
  // acceptance exactly start_i with busy_o low.
  sat_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The capacity register takes a write only while the table is idle and no
  // request is being offered, so a write never lands inside a request.
  sat_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .new_value_i   (new_value_i),
    .position_i    (position_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .placed_at_o   (placed_at_o)
  );

  assign busy_o      = busy;
  assign cfg_ready_o = !busy && !start_i;

endmodule

@@ rtl/core/sat_checker.sv @@
// Port-level checker of the sorted array table, bound to the top level.
`include "sorted_array_table_core_assert.svh"

module sat_checker import sat_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [VAL_W-1:0]  read_value_o,
  input logic [STAT_W-1:0] status_o,
  input logic [ECNT_W-1:0] entry_count_o,
  input logic [PL_W-1:0]   placed_at_o
);

  // An accepted request always raises busy_o in the cycle after acceptance.
  `SAT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // The result strobe comes after the work is done and the block is free.
  `SAT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy_o)

  // Every request is taken in the idle state, which emits no result, so results never come back to back.
  `SAT_ASSERT_NEXT(a_done_gap, clk_i, rst_ni, done_o, !done_o)

  // A rejected request reports zero payload and a count within the depth.
  `SAT_ASSERT_NOW(a_reject_clean, clk_i, rst_ni, done_o && (status_o != ST_OK),
    (read_value_o == '0) && (placed_at_o == '0) && (32'(entry_count_o) <= 32'(DEPTH)))

endmodule

bind sorted_array_table_core sat_checker u_sat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .read_value_o  (read_value_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o),
  .placed_at_o   (placed_at_o)
);

@@ sim/sorted_array_table_core_tb.sv @@
// Self-checking testbench for the sorted array table core: directed table plus random requests.
module sorted_array_table_core_tb;
  import sat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names three operations; the fourth code must be accepted and ignored.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Generous ceiling: about 500 requests at the worst-case insert time plus idle gaps
  // come to well under half a millisecond of simulated time.
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  // Latency margin at the end of the run, a little above the longest request.
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    status_e           status;
    logic [ECNT_W-1:0] count;
    logic [PL_W-1:0]   placed;
  } outcome_t;

  // One line of the directed part. A line either sets the capacity, or issues a
  // request whose outcome is written out by hand or left to the shadow table.
  typedef struct packed {
    logic             set_cap;
    logic [CAP_W-1:0] cap;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    logic             typed;
    outcome_t         exp;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic              busy_o;
  logic [OP_W-1:0]   op_i          = '0;
  logic [VAL_W-1:0]  new_value_i   = '0;
  logic [POS_W-1:0]  position_i    = '0;
  logic              done_o;
  logic [VAL_W-1:0]  read_value_o;
  logic [STAT_W-1:0] status_o;
  logic [ECNT_W-1:0] entry_count_o;
  logic [PL_W-1:0]   placed_at_o;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i    = '0;

  sorted_array_table_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .new_value_i   (new_value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .placed_at_o   (placed_at_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the table contents, fill level and capacity register.
  logic [VAL_W-1:0] shadow_tbl [DEPTH];
  int               shadow_cnt = 0;
  int               shadow_cap = int'(CAP_RESET);

  // Outcomes still owed by the block, oldest first.
  outcome_t outcome_q [$];

  int n_err      = 0;
  int n_req      = 0;
  int n_results  = 0;
  int n_placed   = 0;
  int n_full     = 0;
  int n_range    = 0;
  int n_cfg      = 0;
  int peak_fill  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and returns the outcome it must produce.
  // The insert walk stops at the first entry that is not below the new word, so an
  // equal word lands in front of the copies already stored.
  function automatic outcome_t shadow_apply(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                            logic [POS_W-1:0] pos);
    outcome_t r;
    int       eff_cap;
    int       slot;
    int       k;
    r        = '0;
    r.status = ST_OK;
    eff_cap  = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    case (op)
      OP_INSERT: begin
        if (shadow_cnt >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_cnt && shadow_tbl[slot] < val) slot++;
          for (k = shadow_cnt; k > slot; k--) shadow_tbl[k] = shadow_tbl[k-1];
          shadow_tbl[slot] = val;
          shadow_cnt++;
          r.placed = PL_W'(slot);
        end
      end
      OP_LOOKUP: begin
        if (int'(pos) >= shadow_cnt) r.status = ST_RANGE;
        else r.read_value = shadow_tbl[pos];
      end
      OP_REMOVE: begin
        if (int'(pos) >= shadow_cnt) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(pos); k + 1 < shadow_cnt; k++) shadow_tbl[k] = shadow_tbl[k+1];
          shadow_cnt--;
        end
      end
      default: ;
    endcase
    r.count = ECNT_W'(shadow_cnt);
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                       logic [POS_W-1:0] pos);
    dir_row_t r;
    r     = '0;
    r.op  = op;
    r.val = val;
    r.pos = pos;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                         logic [POS_W-1:0] pos, logic [VAL_W-1:0] rv,
                                         status_e st, logic [ECNT_W-1:0] cnt,
                                         logic [PL_W-1:0] pl);
    dir_row_t r;
    r                = req_row(op, val, pos);
    r.typed          = 1'b1;
    r.exp.read_value = rv;
    r.exp.status     = st;
    r.exp.count      = cnt;
    r.exp.placed     = pl;
    return r;
  endfunction

  function automatic dir_row_t cap_row(logic [CAP_W-1:0] cap);
    dir_row_t r;
    r         = '0;
    r.set_cap = 1'b1;
    r.cap     = cap;
    return r;
  endfunction

  // Drives one request and holds it until the block takes it. The shadow table is
  // updated at the accepting edge. Afterwards the sender may go quiet for a short
  // burst, either right away or once the block has finished, so that gaps land on
  // the start, the middle and the tail of the work. Without a gap start_i stays
  // high and the next request simply overwrites the payload.
  task automatic issue(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                       input logic [POS_W-1:0] pos, input logic typed,
                       input outcome_t typed_exp, input int idle_pct);
    outcome_t pred;
    op_i        <= op;
    new_value_i <= val;
    position_i  <= pos;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pred = shadow_apply(op, val, pos);
    outcome_q.push_back(typed ? typed_exp : pred);
    n_req++;
    if (shadow_cnt > peak_fill) peak_fill = shadow_cnt;
    case (pred.status)
      ST_FULL:  n_full++;
      ST_RANGE: n_range++;
      default:  if (op == OP_INSERT) n_placed++;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      if ($urandom_range(1) == 1) begin
        @(posedge clk_i);
        while (busy_o) @(posedge clk_i);
      end
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Lowers start_i and waits until every owed outcome has arrived and the block
  // reports itself idle again.
  task automatic quiesce();
    start_i <= 1'b0;
    while (outcome_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Capacity is only written with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_cap = int'(cap);
    n_cfg++;
  endtask

  function automatic void check_field(string name, logic [VAL_W-1:0] exp_v,
                                      logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      n_err++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Result side: every strobe is matched against the oldest owed outcome.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (outcome_q.size() == 0) begin
        n_err++;
        $display("%0t: result with nothing owed, expected none actual %h/%0d/%0d/%0d",
                 $time, read_value_o, status_o, entry_count_o, placed_at_o);
      end else begin
        want = outcome_q.pop_front();
        check_field("read_value", want.read_value, read_value_o);
        check_field("status", VAL_W'(want.status), VAL_W'(status_o));
        check_field("entry_count", VAL_W'(want.count), VAL_W'(entry_count_o));
        check_field("placed_at", VAL_W'(want.placed), VAL_W'(placed_at_o));
      end
    end
  end

  // Directed part first, then random segments, each under its own capacity.
  initial begin
    dir_row_t         dir_rows [$];
    int               seg_cap [8];
    int               seg_ins [8];
    int               seg_idle [8];
    int               seg;
    int               i;
    int               roll;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      // Empty table after reset: index checks and the unused code.
      typed_row(OP_LOOKUP, 32'h0, 6'd0, 32'h0, ST_RANGE, 7'd0, 6'd0),
      typed_row(OP_REMOVE, 32'h0, 6'd63, 32'h0, ST_RANGE, 7'd0, 6'd0),
      typed_row(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'h0, ST_OK, 7'd0, 6'd0),
      // Extreme words, and equal words going in front of the stored copy.
      typed_row(OP_INSERT, 32'hFFFF_FFFF, 6'd0, 32'h0, ST_OK, 7'd1, 6'd0),
      typed_row(OP_INSERT, 32'h0, 6'd63, 32'h0, ST_OK, 7'd2, 6'd0),
      typed_row(OP_INSERT, 32'h8000_0000, 6'd0, 32'h0, ST_OK, 7'd3, 6'd1),
      typed_row(OP_INSERT, 32'h0, 6'd0, 32'h0, ST_OK, 7'd4, 6'd0),
      typed_row(OP_INSERT, 32'hFFFF_FFFF, 6'd0, 32'h0, ST_OK, 7'd5, 6'd3),
      typed_row(OP_LOOKUP, 32'h0, 6'd4, 32'hFFFF_FFFF, ST_OK, 7'd5, 6'd0),
      typed_row(OP_LOOKUP, 32'h0, 6'd5, 32'h0, ST_RANGE, 7'd5, 6'd0),
      req_row(OP_LOOKUP, 32'h0, 6'd2),
      // Removal at both ends.
      typed_row(OP_REMOVE, 32'h0, 6'd0, 32'h0, ST_OK, 7'd4, 6'd0),
      typed_row(OP_REMOVE, 32'h0, 6'd3, 32'h0, ST_OK, 7'd3, 6'd0),
      req_row(OP_INSERT, 32'h7FFF_FFFF, 6'd0),
      // Capacity equal to the fill level, then below it.
      cap_row(7'd4),
      typed_row(OP_INSERT, 32'h5, 6'd0, 32'h0, ST_FULL, 7'd4, 6'd0),
      cap_row(7'd1),
      typed_row(OP_INSERT, 32'h0, 6'd0, 32'h0, ST_FULL, 7'd4, 6'd0),
      req_row(OP_LOOKUP, 32'h0, 6'd3),
      req_row(OP_REMOVE, 32'h0, 6'd1),
      typed_row(OP_REMOVE, 32'h0, 6'd5, 32'h0, ST_RANGE, 7'd3, 6'd0),
      req_row(OP_REMOVE, 32'h0, 6'd0),
      req_row(OP_REMOVE, 32'h0, 6'd0),
      typed_row(OP_INSERT, 32'h0, 6'd0, 32'h0, ST_FULL, 7'd1, 6'd0),
      typed_row(OP_REMOVE, 32'h0, 6'd0, 32'h0, ST_OK, 7'd0, 6'd0),
      typed_row(OP_INSERT, 32'h1234_5678, 6'd0, 32'h0, ST_OK, 7'd1, 6'd0),
      // Zero capacity rejects every insert.
      cap_row(7'd0),
      typed_row(OP_INSERT, 32'h0, 6'd0, 32'h0, ST_FULL, 7'd1, 6'd0),
      // Capacity above the depth is clipped to the depth.
      cap_row(7'd127),
      req_row(OP_INSERT, 32'h1234_5678, 6'd0)
    };

    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_cap) begin
        write_capacity(dir_rows[r].cap);
      end else begin
        issue(dir_rows[r].op, dir_rows[r].val, dir_rows[r].pos, dir_rows[r].typed,
              dir_rows[r].exp, 25);
      end
    end

    // Random segments. The first two lean on inserts so the table fills to the
    // depth; later ones shrink the capacity under the fill level and drain it.
    // A capacity of -1 stands for a random setting. The last segment, and one
    // in the middle, run back to back with no idle cycles.
    seg_cap  = '{64, 127, 20, 0, 127, 1, -1, 64};
    seg_ins  = '{80, 80, 25, 40, 60, 55, 50, 45};
    seg_idle = '{20, 35, 20, 0, 35, 20, 35, 0};

    for (seg = 0; seg < 8; seg++) begin
      write_capacity(seg_cap[seg] < 0 ? CAP_W'($urandom_range(127)) : CAP_W'(seg_cap[seg]));
      for (i = 0; i < 60; i++) begin
        roll = $urandom_range(99);
        if (roll < 2) op = OP_UNUSED;
        else if (roll < 2 + seg_ins[seg]) op = OP_INSERT;
        else if (roll < 17 + seg_ins[seg]) op = OP_LOOKUP;
        else op = OP_REMOVE;

        // Mostly random words; some extremes, some small words for long runs of
        // duplicates, and some copies of an entry already stored.
        roll = $urandom_range(9);
        if (roll < 2) val = ($urandom_range(1) == 1) ? '1 : '0;
        else if (roll < 4) val = VAL_W'($urandom_range(7));
        else if (roll == 4 && shadow_cnt > 0) val = shadow_tbl[$urandom_range(shadow_cnt - 1)];
        else val = $urandom;

        // Indexes are mostly in range so that lookups and removals do real work.
        if (shadow_cnt > 0 && $urandom_range(9) < 8) pos = POS_W'($urandom_range(shadow_cnt - 1));
        else pos = POS_W'($urandom_range(63));

        issue(op, val, pos, 1'b0, '0, seg_idle[seg]);
      end
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d words placed, %0d full rejections, %0d bad indexes.",
             n_req, n_placed, n_full, n_range);
    $display("Checked %0d results over %0d capacity writes; the table peaked at %0d entries.",
             n_results, n_cfg, peak_fill);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run stopped by the watchdog with %0d results still owed.", outcome_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_dp.sv
rtl/core/sorted_array_table_core.sv
rtl/core/sat_checker.sv
sim/sorted_array_table_core_tb.sv
